/* rtl/core/ile_pkg.sv */
// Shared types and codes for the indexed list engine.
// No dependencies; ile_ctrl, ile_datapath and the top unit import this package.
package ile_pkg;

    // Default list capacity in entries
    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RM_FIRST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RM_LAST  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RM_AT    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd7;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input item, decode and start it
        logic step;     // move one entry of the shift walk
        logic put;      // write the inserted value into the opened gap
        logic load;     // load the result into the output register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic plan_shift;  // incoming item needs a shift walk
        logic ins_dir;     // walk in progress opens a gap (insert)
        logic shift_last;  // current step is the final move
        logic out_free;    // output register can take a result
    } dp_sts_t;

endpackage

/* rtl/core/ile_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ile_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* rtl/core/ile_ctrl.sv */
// Sequencing state machine of the indexed list engine.
// Depends on ile_pkg for the command and status structs.
module ile_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ile_pkg::dp_sts_t  sts,
    output ile_pkg::ctl_cmd_t cmd
);
    import ile_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_PUT   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.plan_shift ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.step = 1'b1;
                if (sts.shift_last) begin
                    state_next = sts.ins_dir ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/core/ile_datapath.sv */
// Datapath: command decode, entry count, shift walk pointer, entry RAM, output register.
// Depends on ile_pkg and ile_ram.
module ile_datapath #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ile_pkg::in_item_t  s_item,
    input  ile_pkg::ctl_cmd_t  cmd,
    output ile_pkg::dp_sts_t   sts,
    output logic               m_valid,
    input  logic               m_ready,
    output ile_pkg::out_item_t m_item
);
    import ile_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int OCW_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   pos_reg;
    logic               dir_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               rdsel_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg;

    // Decode signals
    logic [CMP_W-1:0]  idx_ext, cnt_ext, pos_ext;
    logic [CNT_W-1:0]  pos;
    logic [STAT_W-1:0] status;
    logic              full, empty, in_range, ok, is_ins, is_rm, at_end, plan_shift;
    logic              shift_last;

    // RAM port signals
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [VALUE_W-1:0] wr_data, rd_data;
    logic [OCW_W-1:0]   cnt_out;

    // Command decode and checks against the current count
    always_comb begin
        idx_ext  = CMP_W'(s_item.index);
        cnt_ext  = CMP_W'(count_reg);
        full     = (count_reg == CNT_W'(CAPACITY));
        empty    = (count_reg == '0);
        in_range = (idx_ext < cnt_ext);
        is_ins   = s_item.command inside {CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT};
        is_rm    = s_item.command inside {CMD_RM_FIRST, CMD_RM_LAST, CMD_RM_AT};
        pos_ext  = '0;
        status   = ST_OK;
        case (s_item.command)
            CMD_INS_HEAD: begin
                status = full ? ST_FULL : ST_OK;
            end
            CMD_INS_TAIL: begin
                pos_ext = cnt_ext;
                status  = full ? ST_FULL : ST_OK;
            end
            CMD_INS_AT: begin
                pos_ext = idx_ext;
                if (idx_ext > cnt_ext) begin
                    status = ST_BAD;
                end else if (full) begin
                    status = ST_FULL;
                end
            end
            CMD_RM_FIRST: begin
                status = empty ? ST_BAD : ST_OK;
            end
            CMD_RM_LAST: begin
                pos_ext = cnt_ext - CMP_W'(1);
                status  = empty ? ST_BAD : ST_OK;
            end
            CMD_UPDATE, CMD_RM_AT, CMD_READ: begin
                pos_ext = idx_ext;
                status  = in_range ? ST_OK : ST_BAD;
            end
            default: begin
                status = ST_BAD;
            end
        endcase
        ok         = (status == ST_OK);
        pos        = pos_ext[CNT_W-1:0];
        at_end     = is_ins ? (pos_ext == cnt_ext) : (pos_ext + CMP_W'(1) == cnt_ext);
        plan_shift = ok && (is_ins || is_rm) && !at_end;
    end

    // Walk end: insert stops once the gap reaches pos, remove at the new tail
    assign shift_last = dir_reg ? (k_reg - CNT_W'(1) == pos_reg)
                                : (k_reg + CNT_W'(1) == count_reg);

    // RAM port steering
    always_comb begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = '0;
        rd_addr = '0;
        wr_data = rd_data;
        if (cmd.accept && ok) begin
            if (s_item.command == CMD_UPDATE || (is_ins && !plan_shift)) begin
                wr_en   = 1'b1;
                wr_addr = pos[ADDR_W-1:0];
                wr_data = s_item.value;
            end else if (is_ins) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(count_reg - CNT_W'(1));
            end else if (is_rm && plan_shift) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(pos + CNT_W'(1));
            end else if (s_item.command == CMD_READ) begin
                rd_en   = 1'b1;
                rd_addr = pos[ADDR_W-1:0];
            end
        end
        if (cmd.step) begin
            wr_en   = 1'b1;
            wr_addr = k_reg[ADDR_W-1:0];
            if (!shift_last) begin
                rd_en   = 1'b1;
                rd_addr = dir_reg ? ADDR_W'(k_reg - CNT_W'(2)) : ADDR_W'(k_reg + CNT_W'(2));
            end
        end
        if (cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[ADDR_W-1:0];
            wr_data = value_reg;
        end
    end

    ile_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Count, walk pointer and output valid
    always_comb begin
        count_next   = count_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        if (cmd.accept && ok && is_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.accept && ok && is_rm) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.accept) begin
            k_next = is_ins ? count_reg : pos;
        end else if (cmd.step) begin
            k_next = dir_reg ? (k_reg - CNT_W'(1)) : (k_reg + CNT_W'(1));
        end
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item payload and result registers
    assign cnt_out = OCW_W'(count_reg);

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.accept) begin
            pos_reg    <= pos;
            dir_reg    <= is_ins;
            value_reg  <= s_item.value;
            status_reg <= status;
            rdsel_reg  <= ok && (s_item.command == CMD_READ);
        end
        if (cmd.load) begin
            m_item_reg.status     <= status_reg;
            m_item_reg.read_value <= rdsel_reg ? rd_data : '0;
            m_item_reg.count      <= cnt_out[COUNT_W-1:0];
        end
    end

    assign sts.plan_shift = plan_shift;
    assign sts.ins_dir    = dir_reg;
    assign sts.shift_last = shift_last;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_item         = m_item_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_fail_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !ok |=> $stable(count_reg))
        else $error("failed command changed the count");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && rd_en |-> wr_addr != rd_addr)
        else $error("read and write to the same entry in one cycle");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an item not yet taken");
endmodule

/* rtl/core/indexed_list_engine_unit.sv */
// Indexed list engine: bounded ordered list with positional insert, remove, update, read.
// An item without shifts goes straight to the result load; a shifting insert first walks the
// entries and then puts the value into the gap, a shifting remove only walks the entries.
// One item in flight; the next item is taken the cycle after the result loads, and the load
// waits for a free output. Shift walks move one entry per cycle, one read and one write each.
// Reset (aresetn, sync, low) empties the list and clears output valid; entries are not cleared.
module indexed_list_engine_unit #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ile_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ile_pkg::out_item_t m_item
);
    import ile_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    ile_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    ile_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_item (s_item),
        .cmd    (cmd),
        .sts    (sts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );
endmodule
